// ----- design/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared widths, status codes and character constants for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int LEN_W = 10;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(512);

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0]       status_t;

  localparam status_t ST_BUSY = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0c;
  localparam logic [7:0] BYTE_LF = 8'h0a;
  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_HT = 8'h09;

endpackage

// ----- design/jsu_if.sv -----
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for raw token bytes and decoded result beats.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  status_t    status;
  len_t       length;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output length, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input status,
                input length, output ready);
endinterface

// ----- design/json_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// json_string_unescaper
// Byte-serial decoder for one JSON string token: strips the quotes, expands
// escapes and reports completion or error with the decoded length.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ------------------------------------------------
//  in_ch     in   in_byte[7:0], end_of_input
//  out_ch    out  out_byte[7:0], byte_valid, status[1:0], length[9:0]
//  cfg       in   cfg_wr_en, cfg_wr_data[9:0] (max_length)
//
//  One input beat gives exactly one result beat: it is registered in the
//  input register and then in the result register. Throughput is one
//  beat per cycle while out_ch.ready is high; the phase machine decodes
//  in one pass. A stalled result register holds the input register, which
//  then holds in_ch.ready low. Synchronous reset clears the phase machine,
//  both valid flags and sets max_length to 512.
//
module json_string_unescaper import jsu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  jsu_in_if.sink          in_ch,
  jsu_out_if.source       out_ch,
  input  logic            cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  // Phase machine codes.
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  // Hex digit value; valid flag in bit 4.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  // Configuration register.
  len_t max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // Input register.
  logic       in_vld;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;

  // Result register.
  logic       out_vld;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  status_t    status_q;
  len_t       length_q;

  // Decoder state.
  logic [1:0] phase, phase_next;
  logic [2:0] hex_remaining, hex_remaining_next;
  logic [7:0] hex_value, hex_value_next;
  len_t       decoded_count, decoded_count_next;

  logic advance;
  assign advance = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_q <= in_ch.in_byte;
      in_eoi_q  <= in_ch.end_of_input;
    end
  end

  // Decode one byte.
  logic       do_put;      // request to emit put_val
  logic [7:0] put_val;
  logic       fail;
  logic       res_valid;
  logic [7:0] res_byte;
  status_t    res_status;
  len_t       cnt_base;
  logic [4:0] hd;
  logic [7:0] hv;

  always_comb begin
    phase_next         = phase;
    hex_remaining_next = hex_remaining;
    hex_value_next     = hex_value;
    cnt_base           = decoded_count;
    do_put             = 1'b0;
    put_val            = in_byte_q;
    fail               = 1'b0;
    res_status         = ST_BUSY;
    hd                 = hex_digit(in_byte_q);
    hv                 = {hex_value[3:0], hd[3:0]};

    case (phase)
      PH_WAIT: begin
        cnt_base = '0;
        if (in_byte_q != CH_QUOTE || in_eoi_q) begin
          fail = 1'b1;
        end else begin
          phase_next = PH_STR;
        end
      end
      PH_STR: begin
        if (in_byte_q == CH_QUOTE) begin
          phase_next = PH_WAIT;
          res_status = ST_DONE;
        end else if (in_byte_q == CH_BSLASH) begin
          if (in_eoi_q) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_ESC;
          end
        end else begin
          do_put = 1'b1;
        end
      end
      PH_ESC: begin
        case (in_byte_q)
          CH_QUOTE, CH_BSLASH, CH_SLASH: do_put = 1'b1;
          CH_B: begin do_put = 1'b1; put_val = BYTE_BS; end
          CH_F: begin do_put = 1'b1; put_val = BYTE_FF; end
          CH_N: begin do_put = 1'b1; put_val = BYTE_LF; end
          CH_R: begin do_put = 1'b1; put_val = BYTE_CR; end
          CH_T: begin do_put = 1'b1; put_val = BYTE_HT; end
          CH_X, CH_U: begin
            if (in_eoi_q) begin
              fail = 1'b1;
            end else begin
              hex_remaining_next = (in_byte_q == CH_X) ? 3'd2 : 3'd4;
              hex_value_next     = 8'h00;
              phase_next         = PH_HEX;
            end
          end
          default: fail = 1'b1;
        endcase
      end
      default: begin
        // Collect hex digits; a zero count counts as the last digit.
        if (!hd[4]) begin
          fail = 1'b1;
        end else begin
          hex_value_next = hv;
          if (hex_remaining <= 3'd1) begin
            hex_remaining_next = 3'd0;
            do_put             = 1'b1;
            put_val            = hv;
          end else begin
            hex_remaining_next = hex_remaining - 3'd1;
            if (in_eoi_q) begin
              fail = 1'b1;
            end
          end
        end
      end
    endcase

    // Emit a decoded byte unless the limit or buffer end stops it.
    if (do_put) begin
      if (cnt_base >= max_length || cnt_base == '1 || in_eoi_q) begin
        fail = 1'b1;
      end else begin
        cnt_base   = cnt_base + len_t'(1);
        phase_next = PH_STR;
      end
    end

    decoded_count_next = cnt_base;
    res_valid          = do_put && !fail;
    res_byte           = res_valid ? put_val : 8'h00;

    if (fail) begin
      phase_next         = PH_WAIT;
      hex_remaining_next = 3'd0;
      hex_value_next     = 8'h00;
      res_status         = ST_ERR;
    end
  end

  // Advance state and load the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      hex_remaining <= 3'd0;
      hex_value     <= 8'h00;
      decoded_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      hex_remaining <= hex_remaining_next;
      hex_value     <= hex_value_next;
      decoded_count <= decoded_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_q   <= res_byte;
      byte_valid_q <= res_valid;
      status_q     <= res_status;
      length_q     <= decoded_count_next;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.out_byte   = out_byte_q;
  assign out_ch.byte_valid = byte_valid_q;
  assign out_ch.status     = status_q;
  assign out_ch.length     = length_q;

`ifndef SYNTHESIS
  // Hex count only lives while collecting digits.
  a_hex_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEX |-> hex_remaining == 3'd0)
    else $error("hex count left over outside hex phase");

  // A decoded byte beat is always in progress and counted.
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    out_vld && byte_valid_q |-> status_q == ST_BUSY && length_q != '0)
    else $error("decoded byte with bad status or zero length");

  // Error and completion beats carry no byte.
  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    out_vld && status_q != ST_BUSY |-> !byte_valid_q && out_byte_q == 8'h00)
    else $error("byte carried on a done or error beat");

  // After an error or done the machine waits for a new quote.
  a_end_wait: assert property (@(posedge clk) disable iff (rst)
    advance && res_status != ST_BUSY |=> phase == PH_WAIT)
    else $error("phase not back to wait after done or error");
`endif

endmodule
